>>> hw/rtl/xxh_pkg.sv
// Package for the XXH64-style stream hash: primes, lane reset values,
// sequencer state type, multiplier request type and rotate helper. No dependencies.
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  localparam logic [63:0] LANE0_INIT = P1 + P2;
  localparam logic [63:0] LANE1_INIT = P2;
  localparam logic [63:0] LANE2_INIT = 64'd0;
  localparam logic [63:0] LANE3_INIT = 64'd0 - P1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LANE_A,
    ST_LANE_B,
    ST_FIN_SUM,
    ST_WS_A,
    ST_WS_B,
    ST_WS_C,
    ST_BY_A,
    ST_BY_B,
    ST_AV_A,
    ST_AV_B,
    ST_AV_C,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

endpackage

>>> hw/rtl/xxh64_variant_stream_hash.sv
// Top level of the XXH64-style stream hash: sequencer, lane and tail state,
// and one shared registered multiplier. Depends on xxh_pkg and xxh_mul.
//
// Channel  Dir  Beat
// in_      in   tdata = data_word[63:0], byte_count[67:64], pad; tlast = last
// out_     out  tdata = hash_value[63:0]
//
// A word that is buffered is held in the pending words while the block stays idle;
// a word that completes a stripe runs 4 lane rounds on the shared multiplier.
// A last word adds the finish: the lane sum, then each tail word, each tail
// byte and the avalanche, before the result beat is offered.
// rst_n is synchronous; the block takes no beat until the result is taken.
module xxh64_variant_stream_hash import xxh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // data_word, byte_count, zero pad
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // hash_value
);

  state_t      state_r, state_nxt;
  logic [63:0] lane_r [4];
  logic [63:0] pend_r [3];
  logic [1:0]  pcnt_r;
  logic [63:0] len_r;
  logic        seen_r;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        last_r;
  logic [63:0] h_r;
  logic [63:0] t_r;
  logic [1:0]  idx_r;
  logic [1:0]  widx_r;
  logic [3:0]  bidx_r;
  logic        stripe_r;
  logic [1:0]  ph_r;
  mul_req_t    mreq;
  logic [63:0] prod;
  logic [63:0] lane_k;
  logic [63:0] tail_w;
  logic        in_acc;
  logic [3:0]  cnt_in;

  xxh_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  assign in_acc = in_tvalid && in_tready;
  assign cnt_in = (!in_tlast || in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];

  always_comb begin
    case (idx_r)
      2'd0:    lane_k = pend_r[0] ^ pend_r[2];
      2'd1:    lane_k = pend_r[1] ^ word_r;
      2'd2:    lane_k = pend_r[2];
      default: lane_k = word_r;
    endcase
    tail_w = (widx_r == pcnt_r) ? word_r : pend_r[widx_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_in == 4'd8 && pcnt_r == 2'd3) state_nxt = ST_LANE_A;
          else if (in_tlast) state_nxt = ST_FIN_SUM;
        end
      end
      ST_LANE_A: if (ph_r == 2'd1) state_nxt = ST_LANE_B;
      ST_LANE_B: begin
        if (ph_r == 2'd1) begin
          if (idx_r != 2'd3) state_nxt = ST_LANE_A;
          else if (last_r) state_nxt = ST_FIN_SUM;
          else state_nxt = ST_IDLE;
        end
      end
      ST_FIN_SUM: begin
        if (!stripe_r && (pcnt_r != 2'd0 || cnt_r == 4'd8)) state_nxt = ST_WS_A;
        else if (!stripe_r && cnt_r != 4'd0) state_nxt = ST_BY_A;
        else state_nxt = ST_AV_A;
      end
      ST_WS_A: if (ph_r == 2'd1) state_nxt = ST_WS_B;
      ST_WS_B: if (ph_r == 2'd1) state_nxt = ST_WS_C;
      ST_WS_C: begin
        if (ph_r == 2'd1) begin
          if (widx_r == pcnt_r - 2'd1 && cnt_r != 4'd8) begin
            state_nxt = (cnt_r != 4'd0) ? ST_BY_A : ST_AV_A;
          end else if (widx_r == pcnt_r) begin
            state_nxt = ST_AV_A;
          end else begin
            state_nxt = ST_WS_A;
          end
        end
      end
      ST_BY_A: if (ph_r == 2'd1) state_nxt = ST_BY_B;
      ST_BY_B: if (ph_r == 2'd1) state_nxt = (bidx_r == cnt_r - 4'd1) ? ST_AV_A : ST_BY_A;
      ST_AV_A: if (ph_r == 2'd1) state_nxt = ST_AV_B;
      ST_AV_B: if (ph_r == 2'd1) state_nxt = ST_AV_C;
      ST_AV_C: state_nxt = ST_OUT;
      ST_OUT:  if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    out_tdata  = h_r;
    mreq.a     = 64'd0;
    mreq.b     = 64'd0;
    unique case (state_r)
      ST_LANE_A: begin mreq.a = lane_k; mreq.b = P2; end
      ST_LANE_B: begin mreq.a = t_r;    mreq.b = P1; end
      ST_WS_A:   begin mreq.a = tail_w; mreq.b = P2; end
      ST_WS_B:   begin mreq.a = t_r;    mreq.b = P1; end
      ST_WS_C:   begin mreq.a = t_r;    mreq.b = P1; end
      ST_BY_A:   begin mreq.a = {56'd0, word_r[8*bidx_r[2:0] +: 8]}; mreq.b = P5; end
      ST_BY_B:   begin mreq.a = t_r;    mreq.b = P1; end
      ST_AV_A:   begin mreq.a = t_r ^ (t_r >> 33); mreq.b = P2; end
      ST_AV_B:   begin mreq.a = t_r ^ (t_r >> 29); mreq.b = P3; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      lane_r[0] <= LANE0_INIT;
      lane_r[1] <= LANE1_INIT;
      lane_r[2] <= LANE2_INIT;
      lane_r[3] <= LANE3_INIT;
      pcnt_r   <= 2'd0;
      len_r    <= 64'd0;
      seen_r   <= 1'b0;
      ph_r     <= 2'd0;
      idx_r    <= 2'd0;
      widx_r   <= 2'd0;
      bidx_r   <= 4'd0;
      stripe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r != state_nxt) ph_r <= 2'd0;
      else ph_r <= ph_r + 2'd1;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            word_r   <= in_tdata[63:0];
            cnt_r    <= cnt_in;
            last_r   <= in_tlast;
            len_r    <= len_r + {60'd0, cnt_in};
            idx_r    <= 2'd0;
            widx_r   <= 2'd0;
            bidx_r   <= 4'd0;
            stripe_r <= (cnt_in == 4'd8 && pcnt_r == 2'd3);
            if (cnt_in == 4'd8 && pcnt_r != 2'd3 && !in_tlast) begin
              pend_r[pcnt_r] <= in_tdata[63:0];
              pcnt_r <= pcnt_r + 2'd1;
            end
          end
        end
        ST_LANE_A: if (ph_r == 2'd1) t_r <= rotl(lane_r[idx_r] + prod, 31);
        ST_LANE_B: begin
          if (ph_r == 2'd1) begin
            lane_r[idx_r] <= prod;
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              pcnt_r <= 2'd0;
              seen_r <= 1'b1;
            end
          end
        end
        ST_FIN_SUM: begin
          t_r <= (seen_r ? (rotl(lane_r[0], 1) + rotl(lane_r[1], 7) +
                  rotl(lane_r[2], 12) + rotl(lane_r[3], 18)) : P5) + len_r;
          h_r <= 64'd0;
        end
        ST_WS_A: if (ph_r == 2'd1) begin h_r <= t_r; t_r <= rotl(prod, 31); end
        ST_WS_B: if (ph_r == 2'd1) t_r <= rotl(h_r ^ prod, 27);
        ST_WS_C: begin
          if (ph_r == 2'd1) begin
            t_r <= prod + P4;
            widx_r <= widx_r + 2'd1;
          end
        end
        ST_BY_A: if (ph_r == 2'd1) t_r <= rotl(t_r ^ prod, 11);
        ST_BY_B: if (ph_r == 2'd1) begin t_r <= prod; bidx_r <= bidx_r + 4'd1; end
        ST_AV_A: if (ph_r == 2'd1) t_r <= prod;
        ST_AV_B: if (ph_r == 2'd1) t_r <= prod;
        ST_AV_C: begin
          h_r <= t_r ^ (t_r >> 32);
          lane_r[0] <= LANE0_INIT;
          lane_r[1] <= LANE1_INIT;
          lane_r[2] <= LANE2_INIT;
          lane_r[3] <= LANE3_INIT;
          pcnt_r <= 2'd0;
          len_r  <= 64'd0;
          seen_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/xxh_mul.sv
// Shared 64x64 modulo-2^64 multiplier built from 32-bit partial products that are
// registered before the final sum. Depends on xxh_pkg.
module xxh_mul import xxh_pkg::*; (
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod
);

  logic [63:0] ll_r;
  logic [31:0] cross_r;
  logic [63:0] ll_nxt;
  logic [31:0] cross_nxt;
  logic [63:0] lh;
  logic [63:0] hl;

  always_comb begin
    ll_nxt    = {32'd0, req.a[31:0]} * {32'd0, req.b[31:0]};
    lh        = {32'd0, req.a[31:0]} * {32'd0, req.b[63:32]};
    hl        = {32'd0, req.a[63:32]} * {32'd0, req.b[31:0]};
    cross_nxt = lh[31:0] + hl[31:0];
  end

  always_ff @(posedge clk) begin
    ll_r    <= ll_nxt;
    cross_r <= cross_nxt;
  end

  assign prod = ll_r + {cross_r, 32'd0};

endmodule

>>> dv/tb_xxh64_variant_stream_hash.sv
// Self-checking testbench for the XXH64-style variant stream hash: random messages
// are hashed by an in-bench predictor and compared beat by beat with the block output.
// Depends on xxh_pkg and the xxh64_variant_stream_hash RTL.
module tb_xxh64_variant_stream_hash;
  import xxh_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } msg_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  xxh64_variant_stream_hash u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  msg_beat_t   beat_q[$];
  logic [63:0] digest_q[$];
  logic [63:0] lane[4];
  logic [63:0] held[3];
  int unsigned held_n;
  logic [63:0] msg_len;
  logic        striped;
  int unsigned fail_cnt = 0;
  int unsigned digests_seen = 0;
  int unsigned beats_sent = 0;
  longint unsigned cycle_cnt = 0;
  bit          calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;

  function automatic logic [63:0] rol(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_mix(logic [63:0] acc, logic [63:0] k);
    return rol(acc + k * P2, 31) * P1;
  endfunction

  function automatic logic [63:0] fold_word(logic [63:0] h, logic [63:0] w);
    h ^= rol(w * P2, 31) * P1;
    return rol(h, 27) * P1 + P4;
  endfunction

  task automatic clear_hash();
    lane[0] = P1 + P2; lane[1] = P2; lane[2] = '0; lane[3] = 64'd0 - P1;
    held_n = 0; msg_len = '0; striped = 1'b0;
    for (int i = 0; i < 3; i++) held[i] = '0;
  endtask

  task automatic hash_beat(msg_beat_t b);
    int unsigned n;
    logic [63:0] h;
    n = (!b.last || b.nbytes > 8) ? 8 : b.nbytes;
    msg_len += 64'(n);
    if (n == 8) begin
      if (held_n >= 3) begin
        lane[0] = lane_mix(lane[0], held[0] ^ held[2]);
        lane[1] = lane_mix(lane[1], held[1] ^ b.word);
        lane[2] = lane_mix(lane[2], held[2]);
        lane[3] = lane_mix(lane[3], b.word);
        held_n = 0; striped = 1'b1; n = 0;
      end else if (!b.last) begin
        held[held_n] = b.word;
        held_n++;
      end
    end
    if (!b.last) return;
    h = striped ? rol(lane[0], 1) + rol(lane[1], 7) + rol(lane[2], 12) + rol(lane[3], 18) : P5;
    h += msg_len;
    for (int i = 0; i < held_n; i++) h = fold_word(h, held[i]);
    if (n == 8) begin
      h = fold_word(h, b.word);
    end else begin
      for (int i = 0; i < n; i++) begin
        h ^= 64'(b.word[8*i +: 8]) * P5;
        h = rol(h, 11) * P1;
      end
    end
    h ^= h >> 33; h *= P2; h ^= h >> 29; h *= P3; h ^= h >> 32;
    digest_q.push_back(h);
    clear_hash();
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic add_message(int unsigned full_words, logic [3:0] tail, bit noisy);
    msg_beat_t b;
    for (int i = 0; i < full_words; i++) begin
      b.word = rand_word();
      b.nbytes = noisy ? 4'($urandom_range(0, 15)) : 4'd8;
      b.last = 1'b0;
      beat_q.push_back(b);
    end
    b.word = rand_word(); b.nbytes = tail; b.last = 1'b1;
    beat_q.push_back(b);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        hash_beat({in_tdata[63:0], in_tdata[67:64], in_tlast});
        beats_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 11) - 1;
          in_tvalid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          msg_beat_t b;
          b = beat_q.pop_front();
          in_tdata <= {4'd0, b.nbytes, b.word};
          in_tlast <= b.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n && out_tvalid && out_tready) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        $error("hash_value: no digest expected, actual %h", out_tdata);
        fail_cnt++;
      end else begin
        logic [63:0] want;
        want = digest_q.pop_front();
        if (want !== out_tdata) begin
          $error("hash_value mismatch: expected %h actual %h", want, out_tdata);
          fail_cnt++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(1, 11) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    msg_beat_t b;
    clear_hash();
    add_message(0, 4'd0, 0);
    add_message(0, 4'd1, 0);
    add_message(0, 4'd8, 0);
    add_message(0, 4'd15, 0);
    add_message(2, 4'd5, 0);
    add_message(3, 4'd8, 0);
    add_message(3, 4'd3, 0);
    add_message(4, 4'd0, 1);
    b.word = '1; b.nbytes = 4'd8; b.last = 1'b1;
    beat_q.push_back(b);
    b.word = '0; b.nbytes = 4'd9; b.last = 1'b1;
    beat_q.push_back(b);
    while (beat_q.size() < 1000) begin
      if ($urandom_range(0, 5) == 0)
        add_message($urandom_range(0, 40), 4'($urandom_range(0, 15)), 1);
      else
        add_message($urandom_range(0, 12), 4'($urandom_range(0, 8)), 0);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (beat_q.size() < 100);
    calm = 1'b1;
    for (int i = 0; i < 10; i++) add_message($urandom_range(0, 9), 4'($urandom_range(0, 8)), 0);
    wait (beat_q.size() == 0 && !in_tvalid);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d input beats and checked %0d digests.", beats_sent, digests_seen);
    if (fail_cnt == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (cycle_cnt > 400000) begin
      $display("Timeout after %0d cycles.", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
